// File: rtl/hlik_pkg.sv
// Package for the hexapod leg-length inverse kinematics block.
// Holds payload structs, fixed-point constants, anchor tables and the Q30 multiply.
// No dependencies.
package hlik_pkg;

    localparam int POS_W    = 16;
    localparam int ANG_W    = 16;
    localparam int EXT_W    = 20;
    localparam int REST_W   = 15;
    localparam int Q_W      = 32;   // Q30 trig and matrix terms
    localparam int ROT_W    = 33;   // summed matrix entries
    localparam int ANCH_W   = 14;
    localparam int ACC_W    = 48;   // Q42 dot products
    localparam int COMP_W   = 26;   // Q20 leg vector components
    localparam int SQ_W     = 50;
    localparam int SUMSQ_W  = 52;
    localparam int ROOT_W   = 26;
    localparam int LEN_W    = 19;
    localparam int NUM_LEGS = 6;

    // Pipeline shape: trig unit, three matrix stages, four leg stages, square root.
    localparam int SC_LAT    = 20;
    localparam int VLD_DEPTH = SC_LAT + 7 + ROOT_W;
    localparam int POS_DLY   = SC_LAT + 4;

    localparam logic signed [34:0] PI30          = 35'sd3373259426;
    localparam logic signed [34:0] NEG_PI30      = -35'sd3373259426;
    localparam logic signed [34:0] HALF_PI30     = 35'sd1686629713;
    localparam logic signed [34:0] NEG_HALF_PI30 = -35'sd1686629713;
    localparam logic signed [34:0] TWO_PI30      = 35'sd6746518852;
    localparam logic signed [Q_W-1:0] ONE30      = 32'sd1073741824;

    localparam logic [REST_W-1:0] REST_RESET = 15'd8192;
    localparam logic signed [EXT_W:0] EXT_MAX = 21'sd524287;
    localparam logic signed [EXT_W:0] EXT_MIN = -21'sd524288;

    // Horner divisors k*(k+1) and reciprocals floor(2^32/d). Row 0 is the cosine
    // series, row 1 the sine series; the sine row has one step less, so its last
    // entry is never used.
    localparam int LANE_COS  = 0;
    localparam int LANE_SIN  = 1;
    localparam int COS_STEPS = 6;
    localparam int SIN_STEPS = 5;
    localparam logic [7:0] HORNER_DIV [2][6] = '{
        '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2},
        '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6,  8'd1}
    };
    localparam logic [31:0] HORNER_RECIP [2][6] = '{
        '{32'd32537631, 32'd47721858, 32'd76695844, 32'd143165576,
          32'd357913941, 32'd2147483648},
        '{32'd39045157, 32'd59652323, 32'd102261126, 32'd214748364,
          32'd715827882, 32'd0}
    };

    localparam logic signed [ANCH_W-1:0] BASE_ANCHOR [NUM_LEGS][3] = '{
        '{-14'sd414,  14'sd3277,  14'sd1024},
        '{ 14'sd414,  14'sd3277,  14'sd1024},
        '{ 14'sd3043, -14'sd1282, 14'sd1024},
        '{ 14'sd2630, -14'sd1995, 14'sd1024},
        '{-14'sd2634, -14'sd1991, 14'sd1024},
        '{-14'sd3047, -14'sd1274, 14'sd1024}
    };
    localparam logic signed [ANCH_W-1:0] PLAT_ANCHOR [NUM_LEGS][3] = '{
        '{-14'sd2630, 14'sd1995,  -14'sd205},
        '{ 14'sd2630, 14'sd1995,  -14'sd205},
        '{ 14'sd3043, 14'sd1282,  -14'sd205},
        '{ 14'sd414,  -14'sd3277, -14'sd205},
        '{-14'sd414,  -14'sd3277, -14'sd205},
        '{-14'sd3043, 14'sd1282,  -14'sd205}
    };

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [ANG_W-1:0] roll_angle;
        logic signed [ANG_W-1:0] pitch_angle;
        logic signed [ANG_W-1:0] yaw_angle;
    } pose_t;

    typedef struct packed {
        logic signed [EXT_W-1:0] leg0_extension;
        logic signed [EXT_W-1:0] leg1_extension;
        logic signed [EXT_W-1:0] leg2_extension;
        logic signed [EXT_W-1:0] leg3_extension;
        logic signed [EXT_W-1:0] leg4_extension;
        logic signed [EXT_W-1:0] leg5_extension;
    } legs_t;

    // Q30 product truncated toward zero.
    function automatic logic signed [Q_W-1:0] qmul30(input logic signed [Q_W-1:0] a,
                                                     input logic signed [Q_W-1:0] b);
        logic signed [63:0] p;
        logic signed [63:0] pb;
        p  = a * b;
        pb = p[63] ? p + 64'sd1073741823 : p;
        return pb[61:30];
    endfunction

endpackage

// File: rtl/hlik_sincos.sv
// Pipelined Q30 sine and cosine of one Q13 angle, twenty register stages.
// Each Horner step is a multiply, a reciprocal multiply and a correction stage.
// Depends on hlik_pkg.
module hlik_sincos
    import hlik_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [ANG_W-1:0] angle,
    output logic signed [Q_W-1:0]   sin_q,
    output logic signed [Q_W-1:0]   cos_q
);

    logic signed [34:0]    a_ext;
    logic signed [34:0]    a_wrap;
    logic signed [34:0]    a_fold;
    logic                  neg_fold;
    logic signed [Q_W-1:0] x0_reg;
    logic                  neg0_reg;
    logic signed [63:0]    xsq;
    logic [Q_W-1:0]        x2_pipe_reg [16];
    logic signed [Q_W-1:0] x_pipe_reg [16];
    logic                  neg_pipe_reg [19];
    logic signed [64:0]    prod_reg [2][6];
    logic [Q_W-1:0]        mag_reg [2][6];
    logic [Q_W-1:0]        q0_reg [2][6];
    logic                  pneg_reg [2][6];
    logic signed [Q_W-1:0] t_reg [2][6];
    logic signed [Q_W-1:0] smul_reg;
    logic signed [Q_W-1:0] sdly1_reg;
    logic signed [Q_W-1:0] sdly2_reg;

    // Wrap by one turn, then fold into the half turn around zero.
    always_comb begin
        a_ext = $signed({{2{angle[ANG_W-1]}}, angle, 17'b0});
        if (a_ext > PI30) begin
            a_wrap = a_ext - TWO_PI30;
        end else if (a_ext < NEG_PI30) begin
            a_wrap = a_ext + TWO_PI30;
        end else begin
            a_wrap = a_ext;
        end
        neg_fold = 1'b0;
        a_fold   = a_wrap;
        if (a_wrap > HALF_PI30) begin
            a_fold   = PI30 - a_wrap;
            neg_fold = 1'b1;
        end else if (a_wrap < NEG_HALF_PI30) begin
            a_fold   = NEG_PI30 - a_wrap;
            neg_fold = 1'b1;
        end
    end

    assign xsq = x0_reg * x0_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg          <= a_fold[Q_W-1:0];
            neg0_reg        <= neg_fold;
            x2_pipe_reg[0]  <= xsq[61:30];
            x_pipe_reg[0]   <= x0_reg;
            neg_pipe_reg[0] <= neg0_reg;
            for (int j = 1; j < 16; j++) begin
                x2_pipe_reg[j] <= x2_pipe_reg[j-1];
                x_pipe_reg[j]  <= x_pipe_reg[j-1];
            end
            for (int j = 1; j < 19; j++) begin
                neg_pipe_reg[j] <= neg_pipe_reg[j-1];
            end
            smul_reg  <= qmul30(x_pipe_reg[15], t_reg[LANE_SIN][SIN_STEPS-1]);
            sdly1_reg <= smul_reg;
            sdly2_reg <= sdly1_reg;
        end
    end

    for (genvar ln = 0; ln < 2; ln++) begin : g_lane
        for (genvar k = 0; k < COS_STEPS; k++) begin : g_step
            if (ln == LANE_COS || k < SIN_STEPS) begin : g_on
                logic signed [Q_W-1:0] t_in;
                logic signed [64:0]    pabs;
                logic [63:0]           mq;
                logic [39:0]           qd;
                logic [39:0]           rem;
                logic [Q_W-1:0]        q;
                logic signed [Q_W-1:0] sq;

                if (k == 0) begin : g_first
                    assign t_in = ONE30;
                end else begin : g_next
                    assign t_in = t_reg[ln][k-1];
                end

                // Quotient estimate is low by at most one; the remainder fixes it.
                always_comb begin
                    pabs = prod_reg[ln][k][64] ? -prod_reg[ln][k] : prod_reg[ln][k];
                    mq   = pabs[61:30] * HORNER_RECIP[ln][k];
                    qd   = q0_reg[ln][k] * HORNER_DIV[ln][k];
                    rem  = {8'd0, mag_reg[ln][k]} - qd;
                    q    = (rem >= {32'd0, HORNER_DIV[ln][k]}) ? q0_reg[ln][k] + 32'd1
                                                                : q0_reg[ln][k];
                    sq   = pneg_reg[ln][k] ? -$signed(q) : $signed(q);
                end

                always_ff @(posedge aclk) begin
                    if (en) begin
                        prod_reg[ln][k] <= $signed({1'b0, x2_pipe_reg[3*k]}) * t_in;
                        mag_reg[ln][k]  <= pabs[61:30];
                        q0_reg[ln][k]   <= mq[63:32];
                        pneg_reg[ln][k] <= prod_reg[ln][k][64];
                        t_reg[ln][k]    <= ONE30 - sq;
                    end
                end
            end
        end
    end

    assign sin_q = sdly2_reg;
    assign cos_q = neg_pipe_reg[18] ? -t_reg[LANE_COS][COS_STEPS-1]
                                    : t_reg[LANE_COS][COS_STEPS-1];

endmodule

// File: rtl/hlik_isqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Restoring digit-by-digit method on bit pairs of the radicand.
// Depends on hlik_pkg.
module hlik_isqrt
    import hlik_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic [SUMSQ_W-1:0] radicand,
    output logic [ROOT_W-1:0]  root
);

    logic [SUMSQ_W-1:0] v_reg [ROOT_W-1];
    logic [ROOT_W+1:0]  rem_reg [ROOT_W-1];
    logic [ROOT_W-1:0]  q_reg [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_bit
        logic [SUMSQ_W-1:0] v_in;
        logic [ROOT_W+1:0]  rem_in;
        logic [ROOT_W-1:0]  q_in;
        logic [ROOT_W+3:0]  rem_sh;
        logic [ROOT_W+3:0]  trial;
        logic [ROOT_W+3:0]  rem_sub;
        logic               ge;

        if (i == 0) begin : g_first
            assign v_in   = radicand;
            assign rem_in = '0;
            assign q_in   = '0;
        end else begin : g_next
            assign v_in   = v_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign q_in   = q_reg[i-1];
        end

        assign rem_sh  = {rem_in, v_in[2*(ROOT_W-1-i) +: 2]};
        assign trial   = {2'b00, q_in, 2'b01};
        assign ge      = (rem_sh >= trial);
        assign rem_sub = rem_sh - trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[i] <= {q_in[ROOT_W-2:0], ge};
            end
        end

        if (i < ROOT_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    v_reg[i]   <= v_in;
                    rem_reg[i] <= ge ? rem_sub[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
                end
            end
        end
    end

    assign root = q_reg[ROOT_W-1];

endmodule

// File: rtl/hexapod_leg_length_ik.sv
// Hexapod leg-length inverse kinematics: pose in, six leg extensions out.
// Fully pipelined: one pose per cycle while the output is not stalled.
// The pipeline holds the 20-stage trig unit and the 26-stage square root.
// A stalled output holds the pipeline only when its last stage is occupied.
// Reset clears the valid bits and sets the rest length to 2.0; data is not reset.
module hexapod_leg_length_ik
    import hlik_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pose_t             s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output legs_t             m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [REST_W-1:0] cfg_data
);

    logic [VLD_DEPTH-1:0]  vld_reg;
    logic                  m_valid_reg;
    legs_t                 m_data_reg;
    logic [REST_W-1:0]     rest_reg;
    logic                  out_load;
    logic                  pipe_adv;

    logic signed [Q_W-1:0] sr, cr, sp, cp, sy, cy;
    logic signed [Q_W-1:0] cycp_reg, sycr_reg, cysp_reg, sysr_reg, sycp_reg;
    logic signed [Q_W-1:0] cycr_reg, sysp_reg, cysr_reg, cpsr_reg, cpcr_reg;
    logic signed [Q_W-1:0] sp1_reg, sr1_reg, cr1_reg;
    logic signed [Q_W-1:0] cyspsr_reg, cyspcr_reg, syspsr_reg, syspcr_reg;
    logic signed [Q_W-1:0] cycp2_reg, sycr2_reg, sysr2_reg, sycp2_reg;
    logic signed [Q_W-1:0] cycr2_reg, cysr2_reg, cpsr2_reg, cpcr2_reg, sp2_reg;
    logic signed [ROT_W-1:0] rot_reg [3][3];
    logic signed [POS_W-1:0] pos_pipe_reg [POS_DLY][3];
    logic signed [ACC_W-1:0] acc_reg [NUM_LEGS][3];
    logic signed [COMP_W-1:0] comp_next [NUM_LEGS][3];
    logic signed [COMP_W-1:0] comp_reg [NUM_LEGS][3];
    logic [SQ_W-1:0]         sq_reg [NUM_LEGS][3];
    logic [SUMSQ_W-1:0]      sumsq_reg [NUM_LEGS];
    logic [ROOT_W-1:0]       root [NUM_LEGS];
    logic signed [EXT_W-1:0] ext_next [NUM_LEGS];

    // The pipeline moves whenever the output register can take a result or the
    // stage in front of it holds none.
    assign out_load  = !m_valid_reg || m_ready;
    assign pipe_adv  = out_load || !vld_reg[VLD_DEPTH-1];
    assign s_ready   = pipe_adv;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
            rest_reg    <= REST_RESET;
        end else begin
            if (pipe_adv) begin
                vld_reg <= {vld_reg[VLD_DEPTH-2:0], s_valid};
            end
            if (out_load) begin
                m_valid_reg <= vld_reg[VLD_DEPTH-1];
            end
            if (cfg_valid) begin
                rest_reg <= cfg_data;
            end
        end
    end

    hlik_sincos u_roll (
        .aclk  (aclk),
        .en    (pipe_adv),
        .angle (s_data.roll_angle),
        .sin_q (sr),
        .cos_q (cr)
    );

    hlik_sincos u_pitch (
        .aclk  (aclk),
        .en    (pipe_adv),
        .angle (s_data.pitch_angle),
        .sin_q (sp),
        .cos_q (cp)
    );

    hlik_sincos u_yaw (
        .aclk  (aclk),
        .en    (pipe_adv),
        .angle (s_data.yaw_angle),
        .sin_q (sy),
        .cos_q (cy)
    );

    // Rotation matrix in three stages: single products, double products, sums.
    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            cycp_reg <= qmul30(cy, cp);
            sycr_reg <= qmul30(sy, cr);
            cysp_reg <= qmul30(cy, sp);
            sysr_reg <= qmul30(sy, sr);
            sycp_reg <= qmul30(sy, cp);
            cycr_reg <= qmul30(cy, cr);
            sysp_reg <= qmul30(sy, sp);
            cysr_reg <= qmul30(cy, sr);
            cpsr_reg <= qmul30(cp, sr);
            cpcr_reg <= qmul30(cp, cr);
            sp1_reg  <= sp;
            sr1_reg  <= sr;
            cr1_reg  <= cr;

            cyspsr_reg <= qmul30(cysp_reg, sr1_reg);
            cyspcr_reg <= qmul30(cysp_reg, cr1_reg);
            syspsr_reg <= qmul30(sysp_reg, sr1_reg);
            syspcr_reg <= qmul30(sysp_reg, cr1_reg);
            cycp2_reg  <= cycp_reg;
            sycr2_reg  <= sycr_reg;
            sysr2_reg  <= sysr_reg;
            sycp2_reg  <= sycp_reg;
            cycr2_reg  <= cycr_reg;
            cysr2_reg  <= cysr_reg;
            cpsr2_reg  <= cpsr_reg;
            cpcr2_reg  <= cpcr_reg;
            sp2_reg    <= sp1_reg;

            rot_reg[0][0] <= ROT_W'(cycp2_reg);
            rot_reg[0][1] <= ROT_W'(cyspsr_reg) - ROT_W'(sycr2_reg);
            rot_reg[0][2] <= ROT_W'(sysr2_reg) + ROT_W'(cyspcr_reg);
            rot_reg[1][0] <= ROT_W'(sycp2_reg);
            rot_reg[1][1] <= ROT_W'(cycr2_reg) + ROT_W'(syspsr_reg);
            rot_reg[1][2] <= ROT_W'(syspcr_reg) - ROT_W'(cysr2_reg);
            rot_reg[2][0] <= -ROT_W'(sp2_reg);
            rot_reg[2][1] <= ROT_W'(cpsr2_reg);
            rot_reg[2][2] <= ROT_W'(cpcr2_reg);
        end
    end

    // Translation waits alongside the trig, matrix and dot-product stages.
    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            pos_pipe_reg[0][0] <= s_data.pos_x;
            pos_pipe_reg[0][1] <= s_data.pos_y;
            pos_pipe_reg[0][2] <= s_data.pos_z;
            for (int d = 1; d < POS_DLY; d++) begin
                pos_pipe_reg[d] <= pos_pipe_reg[d-1];
            end
        end
    end

    // Leg vector components: rotated anchor (Q42 scaled to Q20) plus translation minus base anchor.
    always_comb begin
        for (int lg = 0; lg < NUM_LEGS; lg++) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [ACC_W-1:0] accb;
                logic signed [COMP_W-1:0] diff;
                accb = acc_reg[lg][i][ACC_W-1] ? acc_reg[lg][i] + ACC_W'(48'sd4194303)
                                               : acc_reg[lg][i];
                diff = (COMP_W'(pos_pipe_reg[POS_DLY-1][i])
                        - COMP_W'(BASE_ANCHOR[lg][i])) <<< 8;
                comp_next[lg][i] = accb[ACC_W-1:22] + diff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            for (int lg = 0; lg < NUM_LEGS; lg++) begin
                for (int i = 0; i < 3; i++) begin
                    logic signed [2*COMP_W-1:0] p;
                    acc_reg[lg][i] <= ACC_W'(rot_reg[i][0]) * ACC_W'(PLAT_ANCHOR[lg][0])
                                    + ACC_W'(rot_reg[i][1]) * ACC_W'(PLAT_ANCHOR[lg][1])
                                    + ACC_W'(rot_reg[i][2]) * ACC_W'(PLAT_ANCHOR[lg][2]);
                    comp_reg[lg][i] <= comp_next[lg][i];
                    p = comp_reg[lg][i] * comp_reg[lg][i];
                    sq_reg[lg][i] <= p[SQ_W-1:0];
                end
                sumsq_reg[lg] <= SUMSQ_W'(sq_reg[lg][0]) + SUMSQ_W'(sq_reg[lg][1])
                               + SUMSQ_W'(sq_reg[lg][2]);
            end
        end
    end

    for (genvar lg = 0; lg < NUM_LEGS; lg++) begin : g_leg
        hlik_isqrt u_isqrt (
            .aclk     (aclk),
            .en       (pipe_adv),
            .radicand (sumsq_reg[lg]),
            .root     (root[lg])
        );
    end

    // Round the Q20 length to Q12, subtract the rest length and saturate.
    always_comb begin
        for (int lg = 0; lg < NUM_LEGS; lg++) begin
            logic [ROOT_W:0]         rnd;
            logic [LEN_W-1:0]        len12;
            logic signed [EXT_W:0]   ext;
            rnd   = {1'b0, root[lg]} + (ROOT_W+1)'(128);
            len12 = rnd[ROOT_W:8];
            ext   = $signed({2'b00, len12}) - $signed({6'b000000, rest_reg});
            if (ext > EXT_MAX) begin
                ext_next[lg] = EXT_MAX[EXT_W-1:0];
            end else if (ext < EXT_MIN) begin
                ext_next[lg] = EXT_MIN[EXT_W-1:0];
            end else begin
                ext_next[lg] = ext[EXT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.leg0_extension <= ext_next[0];
            m_data_reg.leg1_extension <= ext_next[1];
            m_data_reg.leg2_extension <= ext_next[2];
            m_data_reg.leg3_extension <= ext_next[3];
            m_data_reg.leg4_extension <= ext_next[4];
            m_data_reg.leg5_extension <= ext_next[5];
        end
    end

    // An empty final stage must never block a new request.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[VLD_DEPTH-1] |-> s_ready)
        else $error("input blocked while the final pipeline stage is empty");

    // An accepted request enters the first stage.
    a_request_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted request lost at pipeline entry");

    // A stalled pipeline with an occupied final stage freezes and keeps its result.
    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && vld_reg[VLD_DEPTH-1] |=> $stable(vld_reg) && m_valid)
        else $error("pipeline moved while stalled");

endmodule
